@@ rtl/xorshift64_word_generator_defines.svh @@
// Assertion helpers for the xorshift64 word generator.
// All checks run on aclk and are off while aresetn is low.
`ifndef XORSHIFT64_WORD_GENERATOR_DEFINES_SVH
`define XORSHIFT64_WORD_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define XS64_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define XS64_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/xs64_pkg.sv @@
package xs64_pkg;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_VARIANT = 3'd0;
    localparam logic [2:0] REG_SHIFT_A = 3'd1;
    localparam logic [2:0] REG_SHIFT_B = 3'd2;
    localparam logic [2:0] REG_SHIFT_C = 3'd3;
    localparam logic [2:0] REG_SEED    = 3'd4;

    // Shift orderings (L = left, R = logical right)
    localparam logic [2:0] VAR_LA_RB_LC = 3'd0;
    localparam logic [2:0] VAR_RA_LB_RC = 3'd1;
    localparam logic [2:0] VAR_LC_RB_LA = 3'd2;
    localparam logic [2:0] VAR_RC_LB_RA = 3'd3;
    localparam logic [2:0] VAR_LA_LC_RB = 3'd4;
    localparam logic [2:0] VAR_RA_RC_LB = 3'd5;
    localparam logic [2:0] VAR_RB_LA_LC = 3'd6;
    localparam logic [2:0] VAR_LB_RA_RC = 3'd7;

    // Reset values
    localparam logic [2:0]  VARIANT_RST = 3'd0;
    localparam logic [5:0]  SHIFT_A_RST = 6'd13;
    localparam logic [5:0]  SHIFT_B_RST = 6'd7;
    localparam logic [5:0]  SHIFT_C_RST = 6'd17;
    localparam logic [63:0] SEED_RST    = 64'd1;
    // seed 1 stepped once with variant 0, shifts 13/7/17
    localparam logic [63:0] STATE_RST   = 64'h0000_0000_4082_2041;

    typedef struct packed {
        logic [2:0] variant;
        logic [5:0] shift_a;
        logic [5:0] shift_b;
        logic [5:0] shift_c;
    } xs64_cfg_t;

endpackage

@@ rtl/xorshift64_word_generator.sv @@
// xorshift64 word generator. Each accepted request with s_request high yields
// one 32-bit word on the m_ channel in the next cycle; a request with s_request
// low is accepted and yields nothing. Words alternate lower half, then upper
// half, of the 64-bit state, and the state takes one xorshift step when the
// upper half goes out. The block takes one request per cycle as long as
// m_ready is high; a single output register decouples the two sides, so a
// request is still taken in the cycle its pending word is consumed. The rate
// is set by the state loop: one full step (three 64-bit barrel shift-xors)
// from the state register back into itself, all combinational. Registers sit
// on an APB-style port at byte address 8*index: variant (0), shift_a (1),
// shift_b (2), shift_c (3), seed (4). Writing seed loads the state with the
// stepped seed and restarts at the lower half; a zero seed gives zeros
// forever. Configure only while no words are pending. No clearing pass.
`include "xorshift64_word_generator_defines.svh"

module xorshift64_word_generator (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_request,
    // word channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_word,
    output logic        m_upper_half,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // configuration registers
    xs64_pkg::xs64_cfg_t cfg_reg, cfg_next;
    logic [63:0]         seed_reg, seed_next;

    // generator state
    logic [63:0] state_reg, state_next;
    logic        lower_given_reg, lower_given_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_word_reg, m_word_next;
    logic        m_upper_half_reg, m_upper_half_next;

    logic [2:0]  reg_idx;
    logic        cfg_wr;
    logic        seed_wr;
    logic        req_acc;
    logic [63:0] step_in;
    logic [63:0] step_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign seed_wr = cfg_wr && (reg_idx == xs64_pkg::REG_SEED);

    // output register frees up when empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign req_acc = s_valid && s_ready && s_request;

    // one step unit, shared: seed load or upper-half advance
    assign step_in = seed_wr ? pwdata : state_reg;

    xs64_step u_step (
        .cfg       (cfg_reg),
        .state_in  (step_in),
        .state_out (step_out)
    );

    always_comb begin
        cfg_next          = cfg_reg;
        seed_next         = seed_reg;
        state_next        = state_reg;
        lower_given_next  = lower_given_reg;
        m_valid_next      = m_valid_reg;
        m_word_next       = m_word_reg;
        m_upper_half_next = m_upper_half_reg;

        // word channel
        if (s_ready) begin
            m_valid_next = s_valid && s_request;
        end
        if (req_acc) begin
            if (!lower_given_reg) begin
                m_word_next       = state_reg[31:0];
                m_upper_half_next = 1'b0;
                lower_given_next  = 1'b1;
            end else begin
                m_word_next       = state_reg[63:32];
                m_upper_half_next = 1'b1;
                lower_given_next  = 1'b0;
                state_next        = step_out;
            end
        end

        // register writes; seed load wins over a request step
        if (cfg_wr) begin
            case (reg_idx)
                xs64_pkg::REG_VARIANT: cfg_next.variant = pwdata[2:0];
                xs64_pkg::REG_SHIFT_A: cfg_next.shift_a = pwdata[5:0];
                xs64_pkg::REG_SHIFT_B: cfg_next.shift_b = pwdata[5:0];
                xs64_pkg::REG_SHIFT_C: cfg_next.shift_c = pwdata[5:0];
                xs64_pkg::REG_SEED: begin
                    seed_next        = pwdata;
                    state_next       = step_out;
                    lower_given_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        case (reg_idx)
            xs64_pkg::REG_VARIANT: prdata = {61'd0, cfg_reg.variant};
            xs64_pkg::REG_SHIFT_A: prdata = {58'd0, cfg_reg.shift_a};
            xs64_pkg::REG_SHIFT_B: prdata = {58'd0, cfg_reg.shift_b};
            xs64_pkg::REG_SHIFT_C: prdata = {58'd0, cfg_reg.shift_c};
            xs64_pkg::REG_SEED:    prdata = seed_reg;
            default:               prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.variant <= xs64_pkg::VARIANT_RST;
            cfg_reg.shift_a <= xs64_pkg::SHIFT_A_RST;
            cfg_reg.shift_b <= xs64_pkg::SHIFT_B_RST;
            cfg_reg.shift_c <= xs64_pkg::SHIFT_C_RST;
            seed_reg        <= xs64_pkg::SEED_RST;
            state_reg       <= xs64_pkg::STATE_RST;
            lower_given_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            cfg_reg         <= cfg_next;
            seed_reg        <= seed_next;
            state_reg       <= state_next;
            lower_given_reg <= lower_given_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        m_word_reg       <= m_word_next;
        m_upper_half_reg <= m_upper_half_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_word       = m_word_reg;
    assign m_upper_half = m_upper_half_reg;

    // checks
    `XS64_ASSERT_NXT(a_lower_word, req_acc && !lower_given_reg,
        m_valid_reg && !m_upper_half_reg && (m_word_reg == $past(state_reg[31:0])),
        "lower half not delivered")
    `XS64_ASSERT_NXT(a_upper_word, req_acc && lower_given_reg,
        m_valid_reg && m_upper_half_reg && !lower_given_reg &&
        (m_word_reg == $past(state_reg[63:32])),
        "upper half not delivered")
    `XS64_ASSERT_NXT(a_lower_holds, req_acc && !lower_given_reg && !seed_wr,
        $stable(state_reg) && lower_given_reg, "state moved on lower half")
    `XS64_ASSERT_IMP(a_stall_full, !s_ready, m_valid_reg && !m_ready,
        "stalled without pending word")

endmodule

@@ rtl/xs64_step.sv @@
// One xorshift step: three shift-xor stages, order picked by variant.
module xs64_step (
    input  xs64_pkg::xs64_cfg_t cfg,
    input  logic [63:0]         state_in,
    output logic [63:0]         state_out
);

    function automatic logic [63:0] shl_xor(input logic [63:0] s, input logic [5:0] k);
        return s ^ (s << k);
    endfunction

    function automatic logic [63:0] shr_xor(input logic [63:0] s, input logic [5:0] k);
        return s ^ (s >> k);
    endfunction

    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] c;

    assign a = cfg.shift_a;
    assign b = cfg.shift_b;
    assign c = cfg.shift_c;

    always_comb begin
        case (cfg.variant)
            xs64_pkg::VAR_LA_RB_LC: state_out = shl_xor(shr_xor(shl_xor(state_in, a), b), c);
            xs64_pkg::VAR_RA_LB_RC: state_out = shr_xor(shl_xor(shr_xor(state_in, a), b), c);
            xs64_pkg::VAR_LC_RB_LA: state_out = shl_xor(shr_xor(shl_xor(state_in, c), b), a);
            xs64_pkg::VAR_RC_LB_RA: state_out = shr_xor(shl_xor(shr_xor(state_in, c), b), a);
            xs64_pkg::VAR_LA_LC_RB: state_out = shr_xor(shl_xor(shl_xor(state_in, a), c), b);
            xs64_pkg::VAR_RA_RC_LB: state_out = shl_xor(shr_xor(shr_xor(state_in, a), c), b);
            xs64_pkg::VAR_RB_LA_LC: state_out = shl_xor(shl_xor(shr_xor(state_in, b), a), c);
            xs64_pkg::VAR_LB_RA_RC: state_out = shr_xor(shr_xor(shl_xor(state_in, b), a), c);
            default:                state_out = state_in;
        endcase
    end

endmodule
